// ===== src/bite_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the pixel deletion function of the thinning engine.
package bite_pkg;

    localparam int IMG_W   = 64;
    localparam int IMG_H   = 64;
    localparam int ROW_AW  = 6;
    localparam int DIM_W   = 7;
    localparam int CNT_W   = 13;
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 13'd4096;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_THIN  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MARK,
        ST_SWEEP
    } state_t;

    // Ring n[0..7] is N, NE, E, SE, S, SW, W, NW; the centre pixel is known to be set.
    function automatic logic del_pixel(input logic [7:0] n, input logic second);
        logic [3:0] a;
        logic [3:0] b;
        logic [2:0] s4;
        logic [2:0] t4;
        logic [2:0] sd;
        logic [2:0] td;
        logic       ok;
        a  = '0;
        b  = '0;
        s4 = '0;
        t4 = '0;
        sd = '0;
        td = '0;
        for (int k = 0; k < 8; k++) begin
            b = b + 4'(n[k]);
            if (!n[k] && n[(k + 1) % 8]) begin
                a = a + 4'd1;
            end
        end
        for (int k = 0; k < 8; k += 2) begin
            s4 = s4 + 3'(n[k]);
            sd = sd + 3'(n[k + 1]);
            if (!n[k] && n[(k + 2) % 8]) begin
                t4 = t4 + 3'd1;
            end
            if (!n[k + 1] && n[(k + 3) % 8]) begin
                td = td + 3'd1;
            end
        end
        ok = (a == 4'd1) && (b >= 4'd2) && (b <= 4'd6);
        if (!second) begin
            if ((n[0] && n[2] && n[4]) || (n[2] && n[4] && n[6])) begin
                ok = 1'b0;
            end
        end else begin
            if ((n[0] && n[2] && n[6]) || (n[0] && n[4] && n[6])) begin
                ok = 1'b0;
            end
        end
        if (b == 4'd2 && s4 == 3'd3 && t4 == 3'd2 && sd == 3'd4 && td == 3'd2) begin
            ok = 1'b0;
        end
        if (b == 4'd3 && n[2] && n[3] && n[4]) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

// ===== src/binary_image_thinning_engine.sv =====
`timescale 1ns / 1ps
// Top level of the binary image thinning engine: image store, marks store and sequencer.
//
// Commands arrive on the s_ stream and each gives exactly one result on the m_ stream.
// A pixel write answers in the cycle after its transfer; a pixel read answers from
// ST_READ, as the image store is a 64 x 64 bit memory with a registered read port.
// A thin command walks the image a row at a time: each sub-pass reads the rows through
// a three-row window and writes one row of deletion marks a cycle, then sweeps the
// interior rows applying the marks.
// Pairs of sub-passes repeat until a pair deletes nothing; the answer carries the
// number of pairs run, saturating at 4096.
// Only one command is in work at a time; a new one is taken once the result register
// is empty or being emptied in the same cycle, so a stalled receiver holds the block.
// After reset the image store is cleared one row a cycle, during which no command is
// taken; configuration writes are taken at any time.
// Image width and height reset to 64 and act as 64 when written larger.
module binary_image_thinning_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd[1:0], row[7:2], col[13:8], pixel_in[14], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel_out[0], pair_count[13:1], status[14], zero
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wdata
);

    localparam int W = bite_pkg::IMG_W;

    logic [W-1:0] img_mem [bite_pkg::IMG_H];
    logic [W-1:0] mark_mem [bite_pkg::IMG_H];

    bite_pkg::state_t state_reg, state_next;

    logic [bite_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [bite_pkg::DIM_W-1:0] uw, uh;

    logic [bite_pkg::DIM_W-1:0] idx_reg, idx_next;
    logic                       arr_pend_reg, arr_pend_next;
    logic [bite_pkg::ROW_AW-1:0] arr_row_reg, arr_row_next;
    logic                       mk_pend_reg, mk_pend_next;
    logic [bite_pkg::ROW_AW-1:0] mk_row_reg, mk_row_next;
    logic                       sw_pend_reg, sw_pend_next;
    logic [bite_pkg::ROW_AW-1:0] sw_row_reg, sw_row_next;
    logic                       sub_reg, sub_next;
    logic                       changed_reg, changed_next;
    logic [bite_pkg::CNT_W-1:0] count_reg, count_next;
    logic [bite_pkg::ROW_AW-1:0] col_reg, col_next;
    logic                       rstat_reg, rstat_next;

    logic [W-1:0] win0_reg, win1_reg, win2_reg;
    logic [W-1:0] rd_data_reg, mk_data_reg;

    logic                        m_valid_reg, m_valid_next;
    logic [14:0]                 m_data_reg, m_data_next;

    logic [bite_pkg::ROW_AW-1:0] rd_addr;
    logic                        rd_en;
    logic                        row_we;
    logic [bite_pkg::ROW_AW-1:0] row_waddr;
    logic [W-1:0]                row_wdata;
    logic                        bit_we;
    logic                        mark_we;
    logic [W-1:0]                mark_row;

    bite_pkg::cmd_t              in_cmd;
    logic [bite_pkg::ROW_AW-1:0] in_row, in_col;
    logic                        in_pix, in_inside, accept;

    logic [W+1:0] up_p, mid_p, dn_p;

    assign uw = (width_reg  > 7'(W)) ? 7'(W) : width_reg;
    assign uh = (height_reg > 7'(bite_pkg::IMG_H)) ? 7'(bite_pkg::IMG_H) : height_reg;

    assign in_cmd    = bite_pkg::cmd_t'(s_tdata[1:0]);
    assign in_row    = s_tdata[7:2];
    assign in_col    = s_tdata[13:8];
    assign in_pix    = s_tdata[14];
    assign in_inside = ({1'b0, in_row} < uh) && ({1'b0, in_col} < uw);

    assign s_tready = (state_reg == bite_pkg::ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

    assign up_p  = {1'b0, win0_reg, 1'b0};
    assign mid_p = {1'b0, win1_reg, 1'b0};
    assign dn_p  = {1'b0, win2_reg, 1'b0};

    always_comb begin
        logic [7:0] nb;
        for (int c = 0; c < W; c++) begin
            nb[0] = up_p[c + 1];
            nb[1] = up_p[c + 2];
            nb[2] = mid_p[c + 2];
            nb[3] = dn_p[c + 2];
            nb[4] = dn_p[c + 1];
            nb[5] = dn_p[c];
            nb[6] = mid_p[c];
            nb[7] = up_p[c];
            mark_row[c] = win1_reg[c] && (c >= 1) && ((7'(c) + 7'd1) < uw)
                          && bite_pkg::del_pixel(nb, sub_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 7'(W);
            height_reg <= 7'(bite_pkg::IMG_H);
        end else if (cfg_we) begin
            if (cfg_addr == bite_pkg::REG_IMAGE_WIDTH) begin
                width_reg <= cfg_wdata;
            end else begin
                height_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= img_mem[rd_addr];
            mk_data_reg <= mark_mem[rd_addr];
        end
        if (row_we) begin
            img_mem[row_waddr] <= row_wdata;
        end else if (bit_we) begin
            img_mem[in_row][in_col] <= in_pix;
        end
        if (mark_we) begin
            mark_mem[mk_row_reg - 6'd1] <= mark_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (arr_pend_reg) begin
            win0_reg <= win1_reg;
            win1_reg <= win2_reg;
            win2_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bite_pkg::ST_CLEAR;
            idx_reg      <= '0;
            arr_pend_reg <= 1'b0;
            mk_pend_reg  <= 1'b0;
            sw_pend_reg  <= 1'b0;
            sub_reg      <= 1'b0;
            changed_reg  <= 1'b0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            arr_pend_reg <= arr_pend_next;
            mk_pend_reg  <= mk_pend_next;
            sw_pend_reg  <= sw_pend_next;
            sub_reg      <= sub_next;
            changed_reg  <= changed_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
        arr_row_reg <= arr_row_next;
        mk_row_reg  <= mk_row_next;
        sw_row_reg  <= sw_row_next;
        col_reg     <= col_next;
        rstat_reg   <= rstat_next;
        m_data_reg  <= m_data_next;
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        arr_pend_next = 1'b0;
        arr_row_next  = arr_row_reg;
        mk_pend_next  = 1'b0;
        mk_row_next   = mk_row_reg;
        sw_pend_next  = 1'b0;
        sw_row_next   = sw_row_reg;
        sub_next      = sub_reg;
        changed_next  = changed_reg;
        count_next    = count_reg;
        col_next      = col_reg;
        rstat_next    = rstat_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[bite_pkg::ROW_AW-1:0];
        row_we        = 1'b0;
        row_waddr     = idx_reg[bite_pkg::ROW_AW-1:0];
        row_wdata     = '0;
        bit_we        = 1'b0;
        mark_we       = 1'b0;

        unique case (state_reg)
            bite_pkg::ST_CLEAR: begin
                row_we   = 1'b1;
                idx_next = idx_reg + 7'd1;
                if (idx_reg == 7'(bite_pkg::IMG_H - 1)) begin
                    state_next = bite_pkg::ST_IDLE;
                end
            end
            bite_pkg::ST_IDLE: begin
                if (accept) begin
                    col_next   = in_col;
                    rstat_next = !in_inside;
                    unique case (in_cmd)
                        bite_pkg::CMD_WRITE: begin
                            bit_we       = in_inside;
                            m_valid_next = 1'b1;
                            m_data_next  = {!in_inside, 13'd0, 1'b0};
                        end
                        bite_pkg::CMD_READ: begin
                            rd_en      = 1'b1;
                            rd_addr    = in_row;
                            state_next = bite_pkg::ST_READ;
                        end
                        bite_pkg::CMD_THIN: begin
                            idx_next     = '0;
                            sub_next     = 1'b0;
                            changed_next = 1'b0;
                            count_next   = '0;
                            state_next   = bite_pkg::ST_MARK;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                        end
                    endcase
                end
            end
            bite_pkg::ST_READ: begin
                m_valid_next = 1'b1;
                m_data_next  = {rstat_reg, 13'd0, rd_data_reg[col_reg] && !rstat_reg};
                state_next   = bite_pkg::ST_IDLE;
            end
            bite_pkg::ST_MARK: begin
                if (idx_reg < uh) begin
                    rd_en         = 1'b1;
                    arr_pend_next = 1'b1;
                    arr_row_next  = idx_reg[bite_pkg::ROW_AW-1:0];
                    idx_next      = idx_reg + 7'd1;
                end
                if (arr_pend_reg) begin
                    mk_pend_next = (arr_row_reg >= 6'd2);
                    mk_row_next  = arr_row_reg;
                end
                mark_we = mk_pend_reg;
                if (!(idx_reg < uh) && !arr_pend_reg && !mk_pend_reg) begin
                    idx_next   = 7'd1;
                    state_next = bite_pkg::ST_SWEEP;
                end
            end
            bite_pkg::ST_SWEEP: begin
                if ((idx_reg + 7'd1) < uh) begin
                    rd_en        = 1'b1;
                    sw_pend_next = 1'b1;
                    sw_row_next  = idx_reg[bite_pkg::ROW_AW-1:0];
                    idx_next     = idx_reg + 7'd1;
                end
                if (sw_pend_reg) begin
                    row_we    = 1'b1;
                    row_waddr = sw_row_reg;
                    row_wdata = rd_data_reg & ~mk_data_reg;
                    if (|(rd_data_reg & mk_data_reg)) begin
                        changed_next = 1'b1;
                    end
                end
                if (!((idx_reg + 7'd1) < uh) && !sw_pend_reg) begin
                    idx_next = '0;
                    if (!sub_reg) begin
                        sub_next   = 1'b1;
                        state_next = bite_pkg::ST_MARK;
                    end else begin
                        sub_next = 1'b0;
                        if (count_reg < bite_pkg::COUNT_LIMIT) begin
                            count_next = count_reg + 13'd1;
                        end
                        if (changed_reg) begin
                            changed_next = 1'b0;
                            state_next   = bite_pkg::ST_MARK;
                        end else begin
                            m_valid_next = 1'b1;
                            m_data_next  = {1'b0, count_next, 1'b0};
                            state_next   = bite_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = bite_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
